FILE: rtl/roi_pixel_shape_membership_assert.svh
// ----------------------------------------------------------------------------
// roi_pixel_shape_membership_assert.svh
// Assertion macros for the region-of-interest membership block.
// Both macros expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ROI_PIXEL_SHAPE_MEMBERSHIP_ASSERT_SVH
`define ROI_PIXEL_SHAPE_MEMBERSHIP_ASSERT_SVH

// Same-cycle implication
`define RPSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rpsm_pkg.sv
// ----------------------------------------------------------------------------
// rpsm_pkg
// Shared types and constants of the region-of-interest membership block.
// ----------------------------------------------------------------------------
package rpsm_pkg;

  // Region shapes
  typedef enum logic [2:0] {
    SHAPE_RECT   = 3'd0,
    SHAPE_CIRCLE = 3'd1,
    SHAPE_ELLIPS = 3'd2,
    SHAPE_RING   = 3'd3,
    SHAPE_SECTOR = 3'd4
  } shape_kind_t;

  // Register indices on the configuration port
  localparam logic [2:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [2:0] REG_CENTER_X   = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_EXTENT_A   = 3'd3;
  localparam logic [2:0] REG_EXTENT_B   = 3'd4;
  localparam logic [2:0] REG_DIR_A      = 3'd5;
  localparam logic [2:0] REG_DIR_B      = 3'd6;

  localparam int          CFG_DATA_W  = 32;
  localparam int          DIR_FRAC    = 14;            // Q1.14 directions
  localparam logic [31:0] DIR_A_RESET = 32'h4000_0000; // cos 1, sin 0

  // Live configuration, shared by all stages
  typedef struct packed {
    shape_kind_t        shape_kind;
    logic signed [16:0] ctr_x;
    logic signed [16:0] ctr_y;
    logic [15:0]        extent_a;
    logic [15:0]        extent_b;
    logic [31:0]        dir_a;
    logic [31:0]        dir_b;
  } cfg_t;

endpackage

FILE: rtl/rpsm_ofs.sv
// ----------------------------------------------------------------------------
// rpsm_ofs
// Stage 1: scale the pixel coordinate to fixed point and take its offset
// from the region centre.
// ----------------------------------------------------------------------------
module rpsm_ofs #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4,
  parameter int DW         = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [COORD_BITS-1:0]  px,
  input  logic [COORD_BITS-1:0]  py,
  input  rpsm_pkg::cfg_t         cfg,
  output logic                   vld,
  output logic signed [DW-1:0]   dx,
  output logic signed [DW-1:0]   dy
);
  import rpsm_pkg::*;

  logic [DW-1:0]        pxw;
  logic [DW-1:0]        pyw;
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dy_next;

  // pixel << frac, minus the sign-extended centre
  assign pxw     = DW'(px) << FRAC_BITS;
  assign pyw     = DW'(py) << FRAC_BITS;
  assign dx_next = $signed(pxw) - DW'(cfg.ctr_x);
  assign dy_next = $signed(pyw) - DW'(cfg.ctr_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx <= dx_next;
      dy <= dy_next;
    end
  end

endmodule

FILE: rtl/rpsm_prod.sv
// ----------------------------------------------------------------------------
// rpsm_prod
// Stages 2 and 3: squares, rotation and dot products, and the partial
// products of the wide ellipse squares.
// ----------------------------------------------------------------------------
module rpsm_prod #(
  parameter  int DW  = 18,
  localparam int AW  = DW - 1,
  localparam int SQW = 2 * AW,
  localparam int D2W = SQW + 1,
  localparam int TW  = DW + 16,
  localparam int UW  = TW + 1,
  localparam int PW  = AW + 16,
  localparam int PH  = (PW + 1) / 2,
  localparam int PHW = PW - PH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic signed [DW-1:0]  dx,
  input  logic signed [DW-1:0]  dy,
  input  rpsm_pkg::cfg_t        cfg,
  output logic                  vld,
  output logic [D2W-1:0]        d2,
  output logic signed [UW-1:0]  u,
  output logic signed [UW-1:0]  v,
  output logic signed [UW-1:0]  dot2,
  output logic [31:0]           a2,
  output logic [31:0]           b2,
  output logic [2*PHW-1:0]      p_hh,
  output logic [PHW+PH-1:0]     p_hl,
  output logic [2*PH-1:0]       p_ll,
  output logic [2*PHW-1:0]      q_hh,
  output logic [PHW+PH-1:0]     q_hl,
  output logic [2*PH-1:0]       q_ll,
  output logic [31:0]           r_hh,
  output logic [31:0]           r_hl,
  output logic [31:0]           r_ll
);
  import rpsm_pkg::*;

  // ---- stage 2 ----
  logic [AW-1:0]        ax, ay;
  logic signed [15:0]   n1x, n1y, n2x, n2y;
  logic                 vld2;
  logic [SQW-1:0]       dx2, dy2;
  logic signed [TW-1:0] cdx, sdy, cdy, sdx, edx, edy;
  logic [PW-1:0]        p, q;
  logic [31:0]          ab;

  // magnitudes fit AW bits
  assign ax  = dx[DW-1] ? AW'(-dx) : AW'(dx);
  assign ay  = dy[DW-1] ? AW'(-dy) : AW'(dy);
  assign n1x = cfg.dir_a[31:16];
  assign n1y = cfg.dir_a[15:0];
  assign n2x = cfg.dir_b[31:16];
  assign n2y = cfg.dir_b[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= in_vld;
    end
  end

  // one multiplier per lane
  always_ff @(posedge clk) begin
    if (adv) begin
      dx2 <= SQW'(ax) * SQW'(ax);
      dy2 <= SQW'(ay) * SQW'(ay);
      cdx <= TW'(n1x) * TW'(dx);
      sdy <= TW'(n1y) * TW'(dy);
      cdy <= TW'(n1x) * TW'(dy);
      sdx <= TW'(n1y) * TW'(dx);
      edx <= TW'(n2x) * TW'(dx);
      edy <= TW'(n2y) * TW'(dy);
      p   <= PW'(ax) * PW'(cfg.extent_b);
      q   <= PW'(ay) * PW'(cfg.extent_a);
      ab  <= 32'(cfg.extent_a) * 32'(cfg.extent_b);
    end
  end

  // ---- stage 3 ----
  logic [PHW-1:0] p_hi, q_hi;
  logic [PH-1:0]  p_lo, q_lo;

  assign p_hi = p[PW-1:PH];
  assign p_lo = p[PH-1:0];
  assign q_hi = q[PW-1:PH];
  assign q_lo = q[PH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld2;
    end
  end

  // sums of the products, and split squares of p, q and a*b
  always_ff @(posedge clk) begin
    if (adv) begin
      d2   <= D2W'(dx2) + D2W'(dy2);
      u    <= UW'(cdx) + UW'(sdy);
      v    <= UW'(cdy) - UW'(sdx);
      dot2 <= UW'(edx) + UW'(edy);
      a2   <= 32'(cfg.extent_a) * 32'(cfg.extent_a);
      b2   <= 32'(cfg.extent_b) * 32'(cfg.extent_b);
      p_hh <= (2*PHW)'(p_hi) * (2*PHW)'(p_hi);
      p_hl <= (PHW+PH)'(p_hi) * (PHW+PH)'(p_lo);
      p_ll <= (2*PH)'(p_lo) * (2*PH)'(p_lo);
      q_hh <= (2*PHW)'(q_hi) * (2*PHW)'(q_hi);
      q_hl <= (PHW+PH)'(q_hi) * (PHW+PH)'(q_lo);
      q_ll <= (2*PH)'(q_lo) * (2*PH)'(q_lo);
      r_hh <= 32'(ab[31:16]) * 32'(ab[31:16]);
      r_hl <= 32'(ab[31:16]) * 32'(ab[15:0]);
      r_ll <= 32'(ab[15:0]) * 32'(ab[15:0]);
    end
  end

endmodule

FILE: rtl/rpsm_cmp.sv
// ----------------------------------------------------------------------------
// rpsm_cmp
// Stages 4 and 5: per-shape membership tests and the shape selection.
// ----------------------------------------------------------------------------
module rpsm_cmp #(
  parameter  int DW   = 18,
  localparam int AW   = DW - 1,
  localparam int D2W  = 2 * AW + 1,
  localparam int UW   = DW + 17,
  localparam int PW   = AW + 16,
  localparam int PH   = (PW + 1) / 2,
  localparam int PHW  = PW - PH,
  localparam int P2W  = 2 * PW,
  localparam int SUMW = P2W + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [D2W-1:0]        d2,
  input  logic signed [UW-1:0]  u,
  input  logic signed [UW-1:0]  v,
  input  logic signed [UW-1:0]  dot2,
  input  logic [31:0]           a2,
  input  logic [31:0]           b2,
  input  logic [2*PHW-1:0]      p_hh,
  input  logic [PHW+PH-1:0]     p_hl,
  input  logic [2*PH-1:0]       p_ll,
  input  logic [2*PHW-1:0]      q_hh,
  input  logic [PHW+PH-1:0]     q_hl,
  input  logic [2*PH-1:0]       q_ll,
  input  logic [31:0]           r_hh,
  input  logic [31:0]           r_hl,
  input  logic [31:0]           r_ll,
  input  rpsm_pkg::cfg_t        cfg,
  output logic                  vld,
  output logic                  in_roi
);
  import rpsm_pkg::*;

  // ---- stage 4 ----
  logic signed [UW-1:0] half_w, half_h;
  logic                 rect_next, circ_next, ring_next, sect_next;
  logic                 vld4, rect_in, circ_in, ring_in, sect_in;
  logic [P2W-1:0]       p2, q2;
  logic [63:0]          r2;

  // half extents scaled by 2^14
  assign half_w = UW'(cfg.extent_a) << DIR_FRAC;
  assign half_h = UW'(cfg.extent_b) << DIR_FRAC;

  assign rect_next = (u >= -half_w) && (u < half_w) && (v >= -half_h) && (v < half_h);
  assign circ_next = d2 <= D2W'(a2);
  assign ring_next = (d2 >= D2W'(a2)) && (d2 <= D2W'(b2));
  // ring, then dot with first normal >= 0 and second <= 0
  assign sect_next = ring_next && !u[UW-1] && (dot2[UW-1] || (dot2 == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (adv) begin
      vld4 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rect_in <= rect_next;
      circ_in <= circ_next;
      ring_in <= ring_next;
      sect_in <= sect_next;
      // recombine the split squares
      p2 <= (P2W'(p_hh) << (2*PH)) + (P2W'(p_hl) << (PH+1)) + P2W'(p_ll);
      q2 <= (P2W'(q_hh) << (2*PH)) + (P2W'(q_hl) << (PH+1)) + P2W'(q_ll);
      r2 <= (64'(r_hh) << 32) + (64'(r_hl) << 17) + 64'(r_ll);
    end
  end

  // ---- stage 5 ----
  logic ell_in;
  logic in_roi_next;

  // (dx*b)^2 + (dy*a)^2 <= (a*b)^2
  assign ell_in = (SUMW'(p2) + SUMW'(q2)) <= SUMW'(r2);

  always_comb begin
    case (cfg.shape_kind)
      SHAPE_RECT:   in_roi_next = rect_in;
      SHAPE_CIRCLE: in_roi_next = circ_in;
      SHAPE_ELLIPS: in_roi_next = ell_in;
      SHAPE_RING:   in_roi_next = ring_in;
      SHAPE_SECTOR: in_roi_next = sect_in;
      default:      in_roi_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_roi <= in_roi_next;
    end
  end

endmodule

FILE: rtl/roi_pixel_shape_membership.sv
// ----------------------------------------------------------------------------
// roi_pixel_shape_membership
// Tests one pixel coordinate per beat against a configured region: rotated
// rectangle, circle, ellipse, ring or ring sector.
//
//   channel   direction  payload (low bit first)        handshake
//   s_*       in         pixel_x, pixel_y               tvalid/tready
//   m_*       out        inside_res                     tvalid/tready
//   cfg_*     in         register index, write data     cfg_we only
//
// One beat per cycle sustained while the output does not stall; each beat
// passes the offset, products, partial squares, compares and select stages.
// Every stage advances together; a stalled output freezes the whole pipe,
// so s_tready follows m_tready through the output register.
// rst clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "roi_pixel_shape_membership_assert.svh"

module roi_pixel_shape_membership #(
  parameter  int COORD_BITS = 12,
  parameter  int FRAC_BITS  = 4,
  localparam int S_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // pixel_x, pixel_y, zero pad
  // master side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // inside_res, zero pad
  // configuration writes
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_idx,
  input  logic [rpsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpsm_pkg::*;

  localparam int PXW = COORD_BITS + FRAC_BITS;
  localparam int DW  = ((PXW + 1 > 17) ? PXW + 1 : 17) + 1;
  localparam int AW  = DW - 1;
  localparam int D2W = 2 * AW + 1;
  localparam int UW  = DW + 17;
  localparam int PW  = AW + 16;
  localparam int PH  = (PW + 1) / 2;
  localparam int PHW = PW - PH;

  // ---- configuration registers ----
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape_kind <= SHAPE_RECT;
      cfg.ctr_x      <= '0;
      cfg.ctr_y      <= '0;
      cfg.extent_a   <= '0;
      cfg.extent_b   <= '0;
      cfg.dir_a      <= DIR_A_RESET;
      cfg.dir_b      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SHAPE_KIND: cfg.shape_kind <= shape_kind_t'(cfg_data[2:0]);
        REG_CENTER_X:   cfg.ctr_x      <= cfg_data[16:0];
        REG_CENTER_Y:   cfg.ctr_y      <= cfg_data[16:0];
        REG_EXTENT_A:   cfg.extent_a   <= cfg_data[15:0];
        REG_EXTENT_B:   cfg.extent_b   <= cfg_data[15:0];
        REG_DIR_A:      cfg.dir_a      <= cfg_data[31:0];
        REG_DIR_B:      cfg.dir_b      <= cfg_data[31:0];
        default:        ;
      endcase
    end
  end

  // ---- pipeline control ----
  logic adv;
  logic v1, v3, in_roi;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tdata  = {7'b0, in_roi};

  // ---- datapath ----
  logic signed [DW-1:0]  dx, dy;
  logic [D2W-1:0]        d2;
  logic signed [UW-1:0]  u, v, dot2;
  logic [31:0]           a2, b2;
  logic [2*PHW-1:0]      p_hh, q_hh;
  logic [PHW+PH-1:0]     p_hl, q_hl;
  logic [2*PH-1:0]       p_ll, q_ll;
  logic [31:0]           r_hh, r_hl, r_ll;

  rpsm_ofs #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DW         (DW)
  ) u_ofs (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (s_tvalid),
    .px     (s_tdata[COORD_BITS-1:0]),
    .py     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cfg    (cfg),
    .vld    (v1),
    .dx     (dx),
    .dy     (dy)
  );

  rpsm_prod #(
    .DW (DW)
  ) u_prod (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (v1),
    .dx     (dx),
    .dy     (dy),
    .cfg    (cfg),
    .vld    (v3),
    .d2     (d2),
    .u      (u),
    .v      (v),
    .dot2   (dot2),
    .a2     (a2),
    .b2     (b2),
    .p_hh   (p_hh),
    .p_hl   (p_hl),
    .p_ll   (p_ll),
    .q_hh   (q_hh),
    .q_hl   (q_hl),
    .q_ll   (q_ll),
    .r_hh   (r_hh),
    .r_hl   (r_hl),
    .r_ll   (r_ll)
  );

  rpsm_cmp #(
    .DW (DW)
  ) u_cmp (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (v3),
    .d2     (d2),
    .u      (u),
    .v      (v),
    .dot2   (dot2),
    .a2     (a2),
    .b2     (b2),
    .p_hh   (p_hh),
    .p_hl   (p_hl),
    .p_ll   (p_ll),
    .q_hh   (q_hh),
    .q_hl   (q_hl),
    .q_ll   (q_ll),
    .r_hh   (r_hh),
    .r_hl   (r_hl),
    .r_ll   (r_ll),
    .cfg    (cfg),
    .vld    (m_tvalid),
    .in_roi (in_roi)
  );

  // ---- assertions ----
  `RPSM_ASSERT_NEXT(a_stall_freeze, !adv, $stable({v1, v3, m_tvalid}), "pipe moved during stall")
  `RPSM_ASSERT_NEXT(a_entry, adv, v1 == $past(s_tvalid), "input beat lost or invented")
  `RPSM_ASSERT_SAME(a_reset_empty, $past(rst), !v1 && !v3 && !m_tvalid, "pipe not empty after reset")

endmodule
